// ===== hdl/transfer_descriptor_chain_builder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the transfer descriptor chain builder
// Short forms for the clocked checks at the end of the top level. They use
// the clk and rst_n names of the module that includes this file.
// ----------------------------------------------------------------------------
`ifndef TRANSFER_DESCRIPTOR_CHAIN_BUILDER_UNIT_MACROS_SVH
`define TRANSFER_DESCRIPTOR_CHAIN_BUILDER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdcb check failed");

// The consequent must hold in the cycle after the antecedent.
`define TDCB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdcb check failed");

`endif

// ===== hdl/tdcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Transfer descriptor chain builder package
// Shared widths, constants and the structs passed between the sequencer,
// the step unit and the top level.
// ----------------------------------------------------------------------------
package tdcb_pkg;

    localparam int ADDR_W         = 32;
    localparam int LEN_PORT_W     = 19;
    localparam int LENGTH_BITS_DEF = 19;
    localparam int INDEX_W        = 6;
    localparam int BYTE_W         = 15;
    localparam int PAGE_SHIFT     = 12;
    localparam int PAGE_NUM_W     = ADDR_W - PAGE_SHIFT;

    localparam logic [BYTE_W-1:0] CHUNK_ALIGNED   = 15'h5000;
    localparam logic [BYTE_W-1:0] CHUNK_UNALIGNED = 15'h4000;

    // Job state held by the sequencer between descriptors.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [INDEX_W-1:0] index;
        logic               unaligned;
        logic               empty_pending;
    } job_t;

    // One descriptor as produced by the step unit.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_count;
        logic [ADDR_W-1:0] page_one;
        logic [ADDR_W-1:0] page_two;
        logic [ADDR_W-1:0] page_three;
        logic [ADDR_W-1:0] page_four;
        logic              last;
        logic [ADDR_W-1:0] addr_next;
    } step_t;

endpackage

// ===== hdl/transfer_descriptor_chain_builder_unit.sv =====
// ----------------------------------------------------------------------------
// Transfer descriptor chain builder
// Expands one USB transfer job into its chain of transfer descriptors.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid, in_ready   start_address, transfer_length,
//                                append_empty_packet
//  out      out_valid, out_ready descriptor_index, byte_count, page_zero..four,
//                                last_descriptor
//
//  A job is taken in a single handshake, then the shared step unit produces
//  one descriptor per cycle while the output register is free or being
//  emptied; a job of N descriptors (1 to 33) takes N advances, and the next
//  job is accepted in the cycle after the last one enters the output register.
//  rst_n clears the sequencer and the output valid flag at once.
//  While out_ready is low with a descriptor waiting, the sequencer holds and
//  the output register keeps its descriptor unchanged.
//
//  The chunk size is 0x5000 bytes for a page aligned start and 0x4000
//  otherwise, fixed for the whole job. Each descriptor takes the smaller of
//  the remaining length and the chunk. A zero length still yields one empty
//  descriptor, and the empty-packet flag adds one more empty descriptor that
//  closes the chain.
// ----------------------------------------------------------------------------
module transfer_descriptor_chain_builder_unit
    import tdcb_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ADDR_W-1:0]     start_address,
    input  logic [LEN_PORT_W-1:0] transfer_length,
    input  logic                  append_empty_packet,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_W-1:0]    descriptor_index,
    output logic [BYTE_W-1:0]     byte_count,
    output logic [ADDR_W-1:0]     page_zero,
    output logic [ADDR_W-1:0]     page_one,
    output logic [ADDR_W-1:0]     page_two,
    output logic [ADDR_W-1:0]     page_three,
    output logic [ADDR_W-1:0]     page_four,
    output logic                  last_descriptor
);

    `include "transfer_descriptor_chain_builder_unit_macros.svh"

    job_t                   job;
    step_t                  step;
    logic [LENGTH_BITS-1:0] rem;
    logic [LENGTH_BITS-1:0] rem_next;
    logic                   busy;
    logic                   start;
    logic                   advance;

    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]     index_reg;
    logic [BYTE_W-1:0]      bytes_reg;
    logic [ADDR_W-1:0]      page_zero_reg;
    logic [ADDR_W-1:0]      page_one_reg;
    logic [ADDR_W-1:0]      page_two_reg;
    logic [ADDR_W-1:0]      page_three_reg;
    logic [ADDR_W-1:0]      page_four_reg;
    logic                   last_reg;

    // A new job may come in while the previous job's last descriptor is
    // still waiting in the output register.
    assign in_ready = !busy;
    assign start    = in_valid && in_ready;

    // The sequencer moves on whenever the output register is free or is
    // being emptied in this cycle.
    assign advance  = busy && (!out_valid_reg || out_ready);

    tdcb_seq #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_seq (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .start_address       (start_address),
        .transfer_length     (transfer_length),
        .append_empty_packet (append_empty_packet),
        .advance             (advance),
        .step                (step),
        .rem_next            (rem_next),
        .job                 (job),
        .rem                 (rem),
        .busy                (busy)
    );

    tdcb_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .job      (job),
        .rem      (rem),
        .step     (step),
        .rem_next (rem_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Descriptor payload, loaded only when the sequencer advances.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg      <= job.index;
            bytes_reg      <= step.byte_count;
            page_zero_reg  <= job.addr;
            page_one_reg   <= step.page_one;
            page_two_reg   <= step.page_two;
            page_three_reg <= step.page_three;
            page_four_reg  <= step.page_four;
            last_reg       <= step.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign descriptor_index = index_reg;
    assign byte_count       = bytes_reg;
    assign page_zero        = page_zero_reg;
    assign page_one         = page_one_reg;
    assign page_two         = page_two_reg;
    assign page_three       = page_three_reg;
    assign page_four        = page_four_reg;
    assign last_descriptor  = last_reg;

    // An accepted job always starts the sequencer in the next cycle.
    `TDCB_ASSERT_NXT(a_start_runs, start, busy)

    // The chain never grows past 33 descriptors.
    `TDCB_ASSERT_IMP(a_index_bound, busy, job.index <= INDEX_W'(32))

    // Page two of a descriptor lies in the 4 KiB page right after page one.
    `TDCB_ASSERT_IMP(a_pages_step, out_valid_reg,
        page_two_reg[ADDR_W-1:PAGE_SHIFT] ==
        page_one_reg[ADDR_W-1:PAGE_SHIFT] + PAGE_NUM_W'(1))

    // A descriptor that is not last never leaves the sequencer idle.
    `TDCB_ASSERT_NXT(a_not_last_busy, advance && !step.last, busy)

endmodule

// ===== hdl/tdcb_step.sv =====
// ----------------------------------------------------------------------------
// Descriptor step unit
// Shared compare, subtract and add logic that turns the current job state
// into one descriptor and the state for the next one.
// ----------------------------------------------------------------------------
module tdcb_step
    import tdcb_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  job_t                   job,
    input  logic [LENGTH_BITS-1:0] rem,
    output step_t                  step,
    output logic [LENGTH_BITS-1:0] rem_next
);

    localparam int CMP_W = (LENGTH_BITS > BYTE_W) ? LENGTH_BITS : BYTE_W;

    logic [CMP_W-1:0]      rem_ext;
    logic [CMP_W-1:0]      chunk_ext;
    logic [CMP_W-1:0]      bytes_ext;
    logic [PAGE_NUM_W-1:0] page_num;

    always_comb
    begin
        rem_ext   = CMP_W'(rem);
        chunk_ext = job.unaligned ? CMP_W'(CHUNK_UNALIGNED) : CMP_W'(CHUNK_ALIGNED);
        bytes_ext = (rem_ext < chunk_ext) ? rem_ext : chunk_ext;
        rem_next  = rem - bytes_ext[LENGTH_BITS-1:0];
        page_num  = job.addr[ADDR_W-1:PAGE_SHIFT];

        step.byte_count = bytes_ext[BYTE_W-1:0];
        step.page_one   = {page_num + PAGE_NUM_W'(1), {PAGE_SHIFT{1'b0}}};
        step.page_two   = {page_num + PAGE_NUM_W'(2), {PAGE_SHIFT{1'b0}}};
        step.page_three = {page_num + PAGE_NUM_W'(3), {PAGE_SHIFT{1'b0}}};
        step.page_four  = {page_num + PAGE_NUM_W'(4), {PAGE_SHIFT{1'b0}}};
        // The chain ends once the data is used up and no empty packet waits.
        step.last       = (rem_next == '0) && !job.empty_pending;
        step.addr_next  = job.addr + ADDR_W'(bytes_ext[BYTE_W-1:0]);
    end

endmodule

// ===== hdl/tdcb_seq.sv =====
// ----------------------------------------------------------------------------
// Descriptor sequencer
// Loads a job, then walks it one descriptor per advance until the step unit
// reports the last descriptor.
// ----------------------------------------------------------------------------
module tdcb_seq
    import tdcb_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [ADDR_W-1:0]      start_address,
    input  logic [LEN_PORT_W-1:0]  transfer_length,
    input  logic                   append_empty_packet,
    input  logic                   advance,
    input  step_t                  step,
    input  logic [LENGTH_BITS-1:0] rem_next,
    output job_t                   job,
    output logic [LENGTH_BITS-1:0] rem,
    output logic                   busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    job_t                   job_reg, job_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next_q;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        rem_next_q = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    job_next.addr          = start_address;
                    job_next.index         = '0;
                    job_next.unaligned     = |start_address[PAGE_SHIFT-1:0];
                    job_next.empty_pending = append_empty_packet;
                    rem_next_q             = transfer_length[LENGTH_BITS-1:0];
                    state_next             = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    if (step.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        job_next.addr  = step.addr_next;
                        job_next.index = job_reg.index + INDEX_W'(1);
                        rem_next_q     = rem_next;
                        // Data is done, so the next pass is the empty packet.
                        if (rem_next == '0)
                        begin
                            job_next.empty_pending = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        rem_reg <= rem_next_q;
    end

    assign job  = job_reg;
    assign rem  = rem_reg;
    assign busy = (state_reg == ST_RUN);

endmodule

// ===== verif/tb_transfer_descriptor_chain_builder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the transfer descriptor chain builder
// Sends transfer jobs (a directed table, then random jobs) through the input
// channel. For each accepted job, the chain of descriptors it should produce
// is worked out here and checked field by field against the output channel.
// Both channels idle and stall at random. The run ends with one verdict line.
// ----------------------------------------------------------------------------
module tb_transfer_descriptor_chain_builder_unit;

    import tdcb_pkg::*;

    // The block keeps only the low LENGTH_BITS bits of transfer_length.
    localparam int          LENGTH_BITS   = LENGTH_BITS_DEF;
    localparam int unsigned LENGTH_MASK   = (1 << LENGTH_BITS) - 1;

    // A chunk is 0x5000 bytes for a page aligned start and 0x4000 otherwise.
    localparam int unsigned ALIGNED_CHUNK_BYTES   = 32'h5000;
    localparam int unsigned UNALIGNED_CHUNK_BYTES = 32'h4000;
    localparam int unsigned PAGE_BYTES            = 32'h1000;

    localparam int          RANDOM_JOBS      = 302;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int unsigned CYCLE_LIMIT      = 400000;

    // One descriptor as seen on the output channel.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  byte_count;
        logic [ADDR_W-1:0]  page_zero;
        logic [ADDR_W-1:0]  page_one;
        logic [ADDR_W-1:0]  page_two;
        logic [ADDR_W-1:0]  page_three;
        logic [ADDR_W-1:0]  page_four;
        logic               last;
    } descriptor_t;

    // One row of the directed table. Rows whose job yields a single descriptor
    // that is obvious by hand carry that descriptor typed in; the others are
    // left to the predictor.
    typedef struct packed {
        logic [ADDR_W-1:0]     start;
        logic [LEN_PORT_W-1:0] length;
        logic                  empty_packet;
        logic                  typed;
        descriptor_t           typed_result;
    } job_row_t;

    // Ways in which the receiver paces out_ready.
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN_FLIP,
        READY_RARE_STALL,
        READY_CADENCE
    } ready_mode_t;

    localparam int         DIRECTED_JOBS = 18;
    localparam logic [6:0] CADENCE       = 7'b1011001;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ADDR_W-1:0]     start_address = '0;
    logic [LEN_PORT_W-1:0] transfer_length = '0;
    logic                  append_empty_packet = 1'b0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [INDEX_W-1:0]    descriptor_index;
    logic [BYTE_W-1:0]     byte_count;
    logic [ADDR_W-1:0]     page_zero;
    logic [ADDR_W-1:0]     page_one;
    logic [ADDR_W-1:0]     page_two;
    logic [ADDR_W-1:0]     page_three;
    logic [ADDR_W-1:0]     page_four;
    logic                  last_descriptor;

    // Descriptors still owed by the block, oldest first.
    descriptor_t descriptors_due [$];

    job_row_t    directed_jobs [DIRECTED_JOBS];

    int unsigned mismatch_count      = 0;
    int unsigned descriptors_checked = 0;
    int unsigned cycle_count         = 0;
    int unsigned burst_left          = 0;
    bit          long_hold_request   = 1'b0;

    transfer_descriptor_chain_builder_unit #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .start_address       (start_address),
        .transfer_length     (transfer_length),
        .append_empty_packet (append_empty_packet),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .descriptor_index    (descriptor_index),
        .byte_count          (byte_count),
        .page_zero           (page_zero),
        .page_one            (page_one),
        .page_two            (page_two),
        .page_three          (page_three),
        .page_four           (page_four),
        .last_descriptor     (last_descriptor)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: expands one job into the descriptors it must produce and
    // queues them. The chunk size is chosen once, from the job's start, so a
    // job that starts unaligned stays on 0x4000 byte chunks throughout. Zero
    // length still gives one empty descriptor, and the empty-packet flag adds
    // a closing empty descriptor that starts just past the data.
    // ------------------------------------------------------------------------
    function automatic void expand_transfer_job(input logic [ADDR_W-1:0]     start,
                                                input logic [LEN_PORT_W-1:0] length,
                                                input logic                  empty_packet);
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] page_base;
        int unsigned       remaining;
        int unsigned       chunk;
        int unsigned       count;
        int unsigned       bytes;
        descriptor_t       chained;

        addr      = start;
        remaining = int'(length) & LENGTH_MASK;
        chunk     = (addr[PAGE_SHIFT-1:0] != '0) ? UNALIGNED_CHUNK_BYTES : ALIGNED_CHUNK_BYTES;
        count     = (remaining + chunk - 1) / chunk;
        if (count == 0)
            count = 1;
        if (empty_packet)
            count++;

        for (int unsigned i = 0; i < count; i++)
        begin
            bytes               = (remaining < chunk) ? remaining : chunk;
            page_base           = {addr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
            chained.index       = INDEX_W'(i);
            chained.byte_count  = BYTE_W'(bytes);
            chained.page_zero   = addr;
            // Page bases wrap at 32 bits, so a buffer near the top of the
            // address space continues at page zero.
            chained.page_one    = page_base + ADDR_W'(PAGE_BYTES);
            chained.page_two    = page_base + ADDR_W'(2 * PAGE_BYTES);
            chained.page_three  = page_base + ADDR_W'(3 * PAGE_BYTES);
            chained.page_four   = page_base + ADDR_W'(4 * PAGE_BYTES);
            chained.last        = (i + 1 == count);
            descriptors_due.push_back(chained);
            remaining -= bytes;
            addr       = addr + ADDR_W'(bytes);
        end
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string field_name,
                                   input logic [ADDR_W-1:0] seen_value,
                                   input logic [ADDR_W-1:0] want_value);
        mismatch_count++;
        $display("[%0t] MISMATCH descriptor #%0d %s: got 0x%08h, want 0x%08h",
                 $realtime, descriptors_checked, field_name, seen_value, want_value);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Jobs go out in bursts of random length; between bursts in_valid
    // drops for a random number of cycles, and some bursts have no gap at all.
    // A job's expected descriptors are queued at the edge that accepts it.
    // ------------------------------------------------------------------------
    task automatic send_job(input logic [ADDR_W-1:0]     start,
                            input logic [LEN_PORT_W-1:0] length,
                            input logic                  empty_packet,
                            input logic                  typed,
                            input descriptor_t           typed_result);
        int unsigned gap;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;

        start_address       <= start;
        transfer_length     <= length;
        append_empty_packet <= empty_packet;
        in_valid            <= 1'b1;

        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        if (typed)
            descriptors_due.push_back(typed_result);
        else
            expand_transfer_job(start, length, empty_packet);
    endtask

    // Holds the input channel idle until every owed descriptor has arrived.
    task automatic wait_for_chain_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (descriptors_due.size() != 0);
    endtask

    // Random job. Many starts are page aligned or sit near the top of the
    // address space, and many lengths land on or next to a chunk multiple,
    // so the chunk boundaries and the address wrap are hit often.
    task automatic pick_random_job(output logic [ADDR_W-1:0]     start,
                                   output logic [LEN_PORT_W-1:0] length,
                                   output logic                  empty_packet);
        int unsigned pick;
        int unsigned chunk;
        int unsigned chunk_units;

        pick = $urandom_range(0, 9);
        if (pick < 4)
            start = $urandom() & 32'hffff_f000;
        else if (pick == 4)
            start = 32'hfff0_0000 | $urandom_range(0, 32'h000f_ffff);
        else
            start = $urandom();

        chunk = (start[PAGE_SHIFT-1:0] != '0) ? UNALIGNED_CHUNK_BYTES : ALIGNED_CHUNK_BYTES;
        pick  = $urandom_range(0, 19);
        if (pick < 3)
            length = '0;
        else if (pick < 6)
            length = LEN_PORT_W'($urandom_range(1, 255));
        else if (pick < 10)
        begin
            chunk_units = $urandom_range(1, LENGTH_MASK / chunk);
            length      = LEN_PORT_W'(chunk_units * chunk + $urandom_range(0, 2) - 1);
        end
        else if (pick < 12)
            length = LEN_PORT_W'($urandom_range(32'h7f000, 32'h7ffff));
        else
            length = LEN_PORT_W'($urandom());

        empty_packet = 1'($urandom_range(0, 1));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed table, random jobs, then the verdict.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [ADDR_W-1:0]     start;
        logic [LEN_PORT_W-1:0] length;
        logic                  empty_packet;

        // Directed jobs. The first three are typed in: an all-zero job right
        // after reset, the top byte of memory whose pages wrap to zero, and a
        // full aligned chunk at the top page.
        directed_jobs = '{
            '{32'h0000_0000, 19'h00000, 1'b0, 1'b1,
              '{6'd0, 15'h0000, 32'h0000_0000, 32'h0000_1000, 32'h0000_2000,
                32'h0000_3000, 32'h0000_4000, 1'b1}},
            '{32'hffff_ffff, 19'h00001, 1'b0, 1'b1,
              '{6'd0, 15'h0001, 32'hffff_ffff, 32'h0000_0000, 32'h0000_1000,
                32'h0000_2000, 32'h0000_3000, 1'b1}},
            '{32'hffff_f000, 19'h05000, 1'b0, 1'b1,
              '{6'd0, 15'h5000, 32'hffff_f000, 32'h0000_0000, 32'h0000_1000,
                32'h0000_2000, 32'h0000_3000, 1'b1}},
            // Zero length followed by the extra empty packet.
            '{32'h0000_1000, 19'h00000, 1'b1, 1'b0, '0},
            // Longest aligned job, then the longest chain of all: unaligned,
            // maximum length and an empty packet make 33 descriptors.
            '{32'h0000_0000, 19'h7ffff, 1'b0, 1'b0, '0},
            '{32'h0000_0001, 19'h7ffff, 1'b1, 1'b0, '0},
            // Long jobs whose running address wraps past the top.
            '{32'hffff_ff00, 19'h7ffff, 1'b1, 1'b0, '0},
            '{32'hffff_0000, 19'h7ffff, 1'b0, 1'b0, '0},
            // Lengths on and just past a chunk, aligned and unaligned.
            '{32'h1234_5000, 19'h05000, 1'b1, 1'b0, '0},
            '{32'h1234_5000, 19'h05001, 1'b0, 1'b0, '0},
            '{32'h1234_5800, 19'h04000, 1'b0, 1'b0, '0},
            '{32'h1234_5800, 19'h04001, 1'b1, 1'b0, '0},
            '{32'h0000_0fff, 19'h00001, 1'b1, 1'b0, '0},
            // Alternating bit patterns in address and length.
            '{32'haaaa_aaaa, 19'h2aaaa, 1'b0, 1'b0, '0},
            '{32'h5555_5555, 19'h55555, 1'b1, 1'b0, '0},
            '{32'h8000_0000, 19'h40000, 1'b0, 1'b0, '0},
            '{32'h7fff_f000, 19'h3ffff, 1'b1, 1'b0, '0},
            '{32'hffff_fffe, 19'h04fff, 1'b0, 1'b0, '0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_JOBS; row++)
            send_job(directed_jobs[row].start, directed_jobs[row].length,
                     directed_jobs[row].empty_packet, directed_jobs[row].typed,
                     directed_jobs[row].typed_result);

        wait_for_chain_drain();

        for (int n = 0; n < RANDOM_JOBS; n++)
        begin
            // Partway in, the receiver stops for a long stretch while jobs keep
            // coming, so the block backs up and has to stall its input.
            if (n == 60)
                long_hold_request = 1'b1;
            // Twice the sender stops until the block has emptied completely.
            if (n == 150 || n == 240)
                wait_for_chain_drain();
            pick_random_job(start, length, empty_packet);
            send_job(start, length, empty_packet, 1'b0, '0);
        end

        wait_for_chain_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver. out_ready follows one of several pacing modes, switched at
    // random intervals, so stalls can fall on any position within a chain. On
    // request it also holds off for a long stretch that it counts itself.
    // ------------------------------------------------------------------------
    initial
    begin : receiver_pacing
        ready_mode_t mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned cadence_step;

        mode         = READY_ALWAYS;
        mode_left    = 50;
        hold_left    = 0;
        cadence_step = 0;

        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                hold_left         = LONG_HOLD_CYCLES;
            end

            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    READY_ALWAYS:     out_ready <= 1'b1;
                    READY_COIN_FLIP:  out_ready <= 1'($urandom_range(0, 1));
                    READY_RARE_STALL: out_ready <= ($urandom_range(0, 7) != 0);
                    READY_CADENCE:    out_ready <= CADENCE[cadence_step % 7];
                    default:          out_ready <= 1'b1;
                endcase
                cadence_step++;
                if (mode_left == 0)
                begin
                    mode      = ready_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                else
                    mode_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker. Every descriptor transaction is compared with the oldest owed
    // descriptor; a descriptor nobody is waiting for is a failure too.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_descriptors
        descriptor_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (descriptors_due.size() == 0)
                report_mismatch("unexpected descriptor, page_zero", page_zero, '0);
            else
            begin
                want = descriptors_due.pop_front();
                if (descriptor_index !== want.index)
                    report_mismatch("descriptor_index", ADDR_W'(descriptor_index),
                                    ADDR_W'(want.index));
                if (byte_count !== want.byte_count)
                    report_mismatch("byte_count", ADDR_W'(byte_count),
                                    ADDR_W'(want.byte_count));
                if (page_zero !== want.page_zero)
                    report_mismatch("page_zero", page_zero, want.page_zero);
                if (page_one !== want.page_one)
                    report_mismatch("page_one", page_one, want.page_one);
                if (page_two !== want.page_two)
                    report_mismatch("page_two", page_two, want.page_two);
                if (page_three !== want.page_three)
                    report_mismatch("page_three", page_three, want.page_three);
                if (page_four !== want.page_four)
                    report_mismatch("page_four", page_four, want.page_four);
                if (last_descriptor !== want.last)
                    report_mismatch("last_descriptor", ADDR_W'(last_descriptor),
                                    ADDR_W'(want.last));
            end
            descriptors_checked++;
        end
    end

    // A hung handshake or a missing descriptor ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d descriptors still owed",
                     $realtime, cycle_count, descriptors_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
